@@ design/chained_hash_map_assert.svh @@
// Assertion macros for the chained hash map
`ifndef CHAINED_HASH_MAP_ASSERT_SVH
`define CHAINED_HASH_MAP_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define CHM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define CHM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/chm_pkg.sv @@
// Shared types and codes for the chained hash map
package chm_pkg;

	localparam int VAL_W  = 64;
	localparam int TS_W   = 9;
	localparam int KIND_W = 2;
	localparam int STAT_W = 2;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NOP    = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;

	typedef struct packed {
		logic busy;
		logic done;
	} mod_stat_t;

endpackage

@@ design/chm_ram.sv @@
// Generic single-port-write, registered-read RAM
module chm_ram #(
	parameter int W = 8,
	parameter int D = 256
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/chm_mod.sv @@
// Bit-serial modulo unit: remainder of key by table size, one bit per cycle
module chm_mod #(
	parameter int KW = 32,
	parameter int DW = 9,
	parameter int RW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [KW-1:0]     dividend,
	input  logic [DW-1:0]     divisor,
	output chm_pkg::mod_stat_t stat,
	output logic [RW-1:0]     rem
);

	localparam int CNW = $clog2(KW + 1);

	logic [KW-1:0]  dvd_q;
	logic [DW-1:0]  rem_q;
	logic [CNW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [DW:0]    trial;
	logic [DW:0]    diff;

	assign trial = {rem_q, dvd_q[KW-1]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(KW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (trial >= {1'b0, divisor}) begin
				rem_q <= diff[DW-1:0];
			end else begin
				rem_q <= trial[DW-1:0];
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem       = RW'(rem_q);

endmodule

@@ design/chained_hash_map.sv @@
// Top level of the chained hash map: control sequencer, table memories, result register
//
// Requests enter on s_tvalid/s_tready/s_tdata/s_tuser (kind in s_tuser, key and
// value in s_tdata); one result per request leaves on m_tvalid/m_tready/m_tdata.
// table_size is to be written through cfg_wen/cfg_wdata only while the block is idle,
// a rule the block leaves to the user; a write empties the map and applies the new size
// (0 acts as 1, above MAX_ENTRIES as MAX_ENTRIES).
// One request is worked at a time. An insert runs the bit-serial modulo unit over
// KEY_BITS (at most 32) key bits, then reads the free-slot stack, writes the new
// slot and links it behind the bucket tail. Remove and lookup run the modulo, read
// the bucket head and walk the chain, each chain step being one registered read of
// the slot memories. An insert into a full table, and the unused kind, skip the
// modulo unit and go straight to the result. s_tready returns the cycle after a
// result is loaded.
// After reset and after every table_size write a clearing pass over all MAX_ENTRIES
// slots resets bucket heads, tails and the free-slot stack; s_tready is low then.
// The result sits in an output register; while the receiver stalls the block still
// takes a new request and works it, holding its result until the register frees.
`include "chained_hash_map_assert.svh"

module chained_hash_map #(
	parameter int MAX_ENTRIES = 256,
	parameter int KEY_BITS    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // key[31:0], value[95:32]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // status[1:0], found[2], value_out[66:3],
	                              // entry_count[75:67], is_full[76], zero[79:77]
	input  logic        cfg_wen,
	input  logic [8:0]  cfg_wdata
);

	localparam int SW = $clog2(MAX_ENTRIES);
	localparam int PW = SW + 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int VW = chm_pkg::VAL_W;
	localparam int RST_SIZE = (MAX_ENTRIES < 256) ? MAX_ENTRIES : 256;
	localparam logic [PW-1:0] NIL = PW'(MAX_ENTRIES);
	localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_ENTRIES - 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);
	localparam logic [CW-1:0] MAX_M1 = CW'(MAX_ENTRIES - 1);

	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_DIV   = 4'd2;
	localparam logic [3:0] ST_LOOK  = 4'd3;
	localparam logic [3:0] ST_INS1  = 4'd4;
	localparam logic [3:0] ST_INS2  = 4'd5;
	localparam logic [3:0] ST_WHEAD = 4'd6;
	localparam logic [3:0] ST_WALK  = 4'd7;
	localparam logic [3:0] ST_CMP   = 4'd8;
	localparam logic [3:0] ST_DONE  = 4'd9;

	logic [3:0]    state_q;
	logic [SW-1:0] clr_q;
	logic [CW-1:0] size_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] eff_size;

	logic [chm_pkg::KIND_W-1:0] kind_q;
	logic [KW-1:0]              key_q;
	logic [VW-1:0]              val_q;
	logic [SW-1:0]              bkt_q;
	logic [PW-1:0]              cur_q;
	logic [PW-1:0]              prev_q;
	logic [PW-1:0]              tail_q;
	logic [SW-1:0]              slot_q;

	logic [chm_pkg::STAT_W-1:0] status_q;
	logic                       found_q;
	logic [VW-1:0]              vout_q;

	logic        out_valid_q;
	logic [79:0] out_data_q;

	logic               accept;
	logic               out_free;
	logic               out_load;
	logic               mod_start;
	chm_pkg::mod_stat_t mod_stat;
	logic [SW-1:0]      mod_rem;
	logic [KW-1:0]      key_in;

	logic          head_we, tail_we, link_we, slot_we, free_we;
	logic [SW-1:0] head_waddr, link_waddr, free_waddr;
	logic [PW-1:0] head_wdata, tail_wdata, link_wdata;
	logic [SW-1:0] free_wdata, free_raddr;
	logic [PW-1:0] head_rd, tail_rd, link_rd;
	logic [KW-1:0] key_rd;
	logic [VW-1:0] val_rd;
	logic [SW-1:0] free_rd;
	logic          hit;
	logic          rm_hit;

	assign key_in    = s_tdata[KW-1:0];
	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || m_tready;
	assign out_load  = (state_q == ST_DONE) && out_free && !cfg_wen;
	assign mod_start = accept && (s_tuser != chm_pkg::KIND_INSERT || count_q < size_q)
		&& s_tuser != chm_pkg::KIND_NOP;
	assign hit       = (key_rd == key_q);
	assign rm_hit    = (state_q == ST_CMP) && hit && (kind_q == chm_pkg::KIND_REMOVE);

	always_comb begin
		if (cfg_wdata == '0) begin
			eff_size = CW'(1);
		end else if (int'(cfg_wdata) > MAX_ENTRIES) begin
			eff_size = MAX_CNT;
		end else begin
			eff_size = CW'(cfg_wdata);
		end
	end

	chm_mod #(.KW(KW), .DW(CW), .RW(SW)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (key_in),
		.divisor  (size_q),
		.stat     (mod_stat),
		.rem      (mod_rem)
	);

	// memory write ports
	always_comb begin
		head_we    = 1'b0;
		head_waddr = bkt_q;
		head_wdata = NIL;
		tail_we    = 1'b0;
		tail_wdata = NIL;
		link_we    = 1'b0;
		link_waddr = slot_q;
		link_wdata = NIL;
		slot_we    = 1'b0;
		free_we    = 1'b0;
		free_waddr = SW'(MAX_CNT - count_q);
		free_wdata = cur_q[SW-1:0];
		unique case (state_q)
			ST_CLR: begin
				head_we    = 1'b1;
				head_waddr = clr_q;
				tail_we    = 1'b1;
				free_we    = 1'b1;
				free_waddr = clr_q;
				free_wdata = clr_q;
			end
			ST_INS1: begin
				slot_we    = 1'b1;
				link_we    = 1'b1;
				link_waddr = free_rd;
				head_we    = (head_rd == NIL);
				head_wdata = {1'b0, free_rd};
				tail_we    = 1'b1;
				tail_wdata = {1'b0, free_rd};
			end
			ST_INS2: begin
				link_we    = (tail_q != NIL);
				link_waddr = tail_q[SW-1:0];
				link_wdata = {1'b0, slot_q};
			end
			ST_CMP: begin
				head_we    = rm_hit && (prev_q == NIL);
				head_wdata = link_rd;
				link_we    = rm_hit && (prev_q != NIL);
				link_waddr = prev_q[SW-1:0];
				link_wdata = link_rd;
				tail_we    = rm_hit && (tail_q == cur_q);
				tail_wdata = prev_q;
				free_we    = rm_hit;
			end
			default: begin
			end
		endcase
	end

	assign free_raddr = SW'(MAX_M1 - count_q);

	chm_ram #(.W(PW), .D(MAX_ENTRIES)) u_head (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.raddr(bkt_q), .rdata(head_rd)
	);

	chm_ram #(.W(PW), .D(MAX_ENTRIES)) u_tail (
		.clk(clk), .we(tail_we), .waddr(head_waddr), .wdata(tail_wdata),
		.raddr(bkt_q), .rdata(tail_rd)
	);

	chm_ram #(.W(PW), .D(MAX_ENTRIES)) u_link (
		.clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
		.raddr(cur_q[SW-1:0]), .rdata(link_rd)
	);

	chm_ram #(.W(KW), .D(MAX_ENTRIES)) u_key (
		.clk(clk), .we(slot_we), .waddr(free_rd), .wdata(key_q),
		.raddr(cur_q[SW-1:0]), .rdata(key_rd)
	);

	chm_ram #(.W(VW), .D(MAX_ENTRIES)) u_val (
		.clk(clk), .we(slot_we), .waddr(free_rd), .wdata(val_q),
		.raddr(cur_q[SW-1:0]), .rdata(val_rd)
	);

	chm_ram #(.W(SW), .D(MAX_ENTRIES)) u_free (
		.clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
		.raddr(free_raddr), .rdata(free_rd)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			size_q      <= CW'(RST_SIZE);
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wen) begin
				size_q  <= eff_size;
				state_q <= ST_CLR;
				clr_q   <= '0;
				count_q <= '0;
			end else begin
				unique case (state_q)
					ST_CLR: begin
						clr_q <= clr_q + 1'b1;
						if (clr_q == LAST_SLOT) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (accept) begin
							state_q <= mod_start ? ST_DIV : ST_DONE;
						end
					end
					ST_DIV: begin
						if (mod_stat.done) begin
							state_q <= ST_LOOK;
						end
					end
					ST_LOOK: begin
						state_q <= (kind_q == chm_pkg::KIND_INSERT) ? ST_INS1 : ST_WHEAD;
					end
					ST_INS1: begin
						count_q <= count_q + 1'b1;
						state_q <= ST_INS2;
					end
					ST_INS2: begin
						state_q <= ST_DONE;
					end
					ST_WHEAD: begin
						state_q <= (head_rd == NIL) ? ST_DONE : ST_WALK;
					end
					ST_WALK: begin
						state_q <= ST_CMP;
					end
					ST_CMP: begin
						if (rm_hit) begin
							count_q <= count_q - 1'b1;
						end
						if (hit || link_rd == NIL) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_WALK;
						end
					end
					ST_DONE: begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_CLR;
						clr_q   <= '0;
					end
				endcase
			end
		end
	end

	// request and walk payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= s_tuser;
			key_q    <= key_in;
			val_q    <= s_tdata[32+VW-1:32];
			found_q  <= 1'b0;
			vout_q   <= '0;
			status_q <= (s_tuser == chm_pkg::KIND_INSERT && !mod_start) ?
				chm_pkg::STAT_FULL : chm_pkg::STAT_OK;
		end
		if (state_q == ST_DIV && mod_stat.done) begin
			bkt_q <= mod_rem;
		end
		if (state_q == ST_INS1) begin
			slot_q <= free_rd;
			tail_q <= tail_rd;
		end
		if (state_q == ST_WHEAD) begin
			cur_q  <= head_rd;
			prev_q <= NIL;
			tail_q <= tail_rd;
			if (head_rd == NIL && kind_q == chm_pkg::KIND_REMOVE) begin
				status_q <= chm_pkg::STAT_NOTFOUND;
			end
		end
		if (state_q == ST_CMP) begin
			if (hit) begin
				if (kind_q == chm_pkg::KIND_LOOKUP) begin
					found_q <= 1'b1;
					vout_q  <= val_rd;
				end
			end else begin
				prev_q <= cur_q;
				cur_q  <= link_rd;
				if (link_rd == NIL && kind_q == chm_pkg::KIND_REMOVE) begin
					status_q <= chm_pkg::STAT_NOTFOUND;
				end
			end
		end
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= {3'b000, (count_q == size_q), 9'(count_q), vout_q, found_q,
				status_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`CHM_ASSERT_NOW(a_count_le_size, 1'b1, count_q <= size_q, "entry count above table size")
	`CHM_ASSERT_NEXT(a_insert_counts, state_q == ST_INS1 && !cfg_wen,
		count_q == $past(count_q) + 1'b1, "insert did not add one entry")
	`CHM_ASSERT_NEXT(a_clear_empties, state_q == ST_CLR,
		count_q == '0, "entries present during clearing pass")
	`CHM_ASSERT_NOW(a_walk_slot, state_q == ST_WALK, cur_q != NIL, "chain walk on empty link")

endmodule
